@@ rtl/core/fiws_pkg.sv @@
package fiws_pkg;

  // Default sizing of the interval window.
  localparam int WINDOW_DEF     = 256;
  localparam int IV_WIDTH_DEF   = 24;

  // Fixed field widths.
  localparam int TS_W           = 32;
  localparam int FRAC_W         = 16;
  localparam int RATE_W         = 28;
  localparam int MEAN_W         = 24;
  localparam int CFG_IDX_W      = 8;
  localparam int QUOT_BITS      = 28;

  // Rate numerator (256e6, frames per second in Q.8) and saturation values.
  localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;
  localparam logic [RATE_W-1:0] RATE_MAX = 28'd268435455;
  localparam logic [MEAN_W-1:0] MEAN_MAX = 24'd16777215;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_B = 8'd1;
  localparam logic [FRAC_W-1:0]    LOW_A_RST = 16'd655;
  localparam logic [FRAC_W-1:0]    LOW_B_RST = 16'd65;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RING_RD,
    ST_RING_UPD,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_DIVIDE,
    ST_OUTPUT
  } back_state_t;

  // Progress of the remove-and-insert sweep over the sorted window.
  typedef enum logic [1:0] {
    PH_SEEK,
    PH_SHIFT,
    PH_COPY
  } sweep_phase_t;

  // Status reported by the back end to the top level.
  typedef struct packed {
    logic clear_done;
  } back_status_t;

endpackage

@@ rtl/core/frame_interval_window_stats.sv @@
// Sliding-window frame interval statistics. Each transfer on the input
// carries a frame-start timestamp in microseconds; the first one after reset
// only records the time, every later one pushes the wrapped interval into a
// WINDOW-entry window, and each one yields one result: the current rate, the mean
// interval and two low-percentile rates, all rates as frames per second in
// Q.8 (256e6 / interval, saturated for a zero interval). After reset the
// block clears the window memories and accepts no item meanwhile. Each
// item then passes through the back end: one pass over the sorted-window
// memory, one element per cycle, followed by three rate divisions in the
// single shared serial divider, plus any time the finished result waits
// for the receiver. A two-entry queue lets the input take up to two further
// items while one is being worked on.
module frame_interval_window_stats
  import fiws_pkg::*;
#(
  parameter int WINDOW         = WINDOW_DEF,
  parameter int INTERVAL_WIDTH = IV_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TS_W-1:0]      timestamp_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RATE_W-1:0]    current_rate_q8,
  output logic [MEAN_W-1:0]    mean_interval_us,
  output logic [RATE_W-1:0]    low_rate_a_q8,
  output logic [RATE_W-1:0]    low_rate_b_q8,
  output logic                 sample_taken,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_W-1:0]    cfg_data
);

  logic [FRAC_W-1:0]     frac_a;
  logic [FRAC_W-1:0]     frac_b;
  logic                  accept;
  logic                  push;
  logic [INTERVAL_WIDTH:0] push_data;
  logic                  q_full;
  logic                  q_pop;
  logic [INTERVAL_WIDTH:0] q_data;
  logic                  q_avail;
  back_status_t          back_st;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_a <= LOW_A_RST;
      frac_b <= LOW_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_A: frac_a <= cfg_data;
        REG_LOW_B: frac_b <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Input transfers wait while the queue is full or the window is cleared.
  assign in_stall = q_full || !back_st.clear_done;
  assign accept   = in_valid && !in_stall;

  fiws_front #(.IW(INTERVAL_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .timestamp_us (timestamp_us),
    .push         (push),
    .push_data    (push_data)
  );

  fiws_queue #(.DW(INTERVAL_WIDTH + 1)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .avail     (q_avail)
  );

  fiws_back #(.WINDOW(WINDOW), .IW(INTERVAL_WIDTH)) u_back (
    .clk              (clk),
    .rst              (rst),
    .frac_a           (frac_a),
    .frac_b           (frac_b),
    .item_avail       (q_avail),
    .item_data        (q_data),
    .item_pop         (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .current_rate_q8  (current_rate_q8),
    .mean_interval_us (mean_interval_us),
    .low_rate_a_q8    (low_rate_a_q8),
    .low_rate_b_q8    (low_rate_b_q8),
    .sample_taken     (sample_taken),
    .status           (back_st)
  );

  // No item enters before the clearing pass has finished.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    accept |-> back_st.clear_done)
    else $error("input transfer accepted during clearing pass");

  // No result is offered while the window is still being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    !back_st.clear_done |-> !out_valid)
    else $error("result offered during clearing pass");

  // The queue is never pushed while full.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

endmodule

@@ rtl/core/fiws_queue.sv @@
module fiws_queue
  import fiws_pkg::*;
#(
  parameter int DW = IV_WIDTH_DEF + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          avail
);

  logic [DW-1:0] slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign avail    = (count != 2'd0);
  assign pop_data = slots[rd_ptr];

  // Two-entry queue between the front end and the back end.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && avail) begin
        rd_ptr <= ~rd_ptr;
      end
      if ((push && !full) && !(pop && avail)) begin
        count <= count + 2'd1;
      end else if (!(push && !full) && (pop && avail)) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/fiws_front.sv @@
module fiws_front
  import fiws_pkg::*;
#(
  parameter int IW = IV_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [TS_W-1:0] timestamp_us,
  output logic            push,
  output logic [IW:0]     push_data
);

  logic [TS_W-1:0] prev_ts;
  logic            started;
  logic [TS_W-1:0] diff;
  logic [TS_W-1:0] diff_hi;
  logic [IW-1:0]   iv;

  // Wrapped difference, saturated to the interval width.
  assign diff    = timestamp_us - prev_ts;
  assign diff_hi = diff >> IW;
  assign iv      = (diff_hi != '0) ? '1 : diff[IW-1:0];

  // The first item after reset is pushed with the started flag low; it only records its timestamp.
  assign push      = accept;
  assign push_data = {started, iv};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ts <= '0;
      started <= 1'b0;
    end else if (accept) begin
      prev_ts <= timestamp_us;
      started <= 1'b1;
    end
  end

endmodule

@@ rtl/core/fiws_div.sv @@
module fiws_div
  import fiws_pkg::*;
#(
  parameter int IW = IV_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IW-1:0]     divisor,
  output logic              done,
  output logic [RATE_W-1:0] quotient
);

  logic                busy;
  logic [4:0]          cnt;
  logic [IW-1:0]       rem;
  logic [IW-1:0]       dvs;
  logic [IW:0]         trial;
  logic [IW:0]         trial_sub;
  logic                ge;

  // One quotient bit per cycle of restoring division.
  assign trial     = {rem, RATE_NUM[cnt]};
  assign trial_sub = trial - {1'b0, dvs};
  assign ge        = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (divisor == '0) begin
          // A zero interval saturates the rate.
          quotient <= RATE_MAX;
          done     <= 1'b1;
        end else begin
          busy     <= 1'b1;
          cnt      <= 5'(QUOT_BITS - 1);
          rem      <= '0;
          dvs      <= divisor;
          quotient <= '0;
        end
      end else if (busy) begin
        rem      <= ge ? trial_sub[IW-1:0] : trial[IW-1:0];
        quotient <= {quotient[RATE_W-2:0], ge};
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

@@ rtl/core/fiws_back.sv @@
module fiws_back
  import fiws_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int IW     = IV_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [FRAC_W-1:0] frac_a,
  input  logic [FRAC_W-1:0] frac_b,
  input  logic              item_avail,
  input  logic [IW:0]       item_data,
  output logic              item_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RATE_W-1:0] current_rate_q8,
  output logic [MEAN_W-1:0] mean_interval_us,
  output logic [RATE_W-1:0] low_rate_a_q8,
  output logic [RATE_W-1:0] low_rate_b_q8,
  output logic              sample_taken,
  output back_status_t      status
);

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = AW + 1;
  localparam int SUMW = IW + AW;

  // Interval ring and its sorted copy.
  logic [IW-1:0] ring   [WINDOW];
  logic [IW-1:0] sorted [WINDOW];

  back_state_t   state, state_next;
  sweep_phase_t  phase, ph_next;

  logic [AW-1:0]     clr;
  logic [AW-1:0]     ptr;
  logic [SUMW-1:0]   sum;
  logic [IW-1:0]     newest;
  logic [IW-1:0]     cur_iv;
  logic              cur_taken;
  logic [IW-1:0]     old_v;
  logic              left;
  logic [CW-1:0]     k;
  logic [IW-1:0]     carry, carry_next;
  logic [IW-1:0]     cap_a, cap_b;
  logic [1:0]        div_sel;
  logic              div_go;
  logic [RATE_W-1:0] rate_cur, rate_a, rate_b;

  logic [IW-1:0]     ring_q, sort_q;
  logic              ring_re, ring_we;
  logic [AW-1:0]     ring_addr;
  logic [IW-1:0]     ring_wdata;
  logic              sort_re, sort_we;
  logic [AW-1:0]     sort_raddr, sort_waddr;
  logic [IW-1:0]     sort_wdata;
  logic              keep_cap;
  logic              div_start, div_done, out_load;
  logic [IW-1:0]     div_dvs;
  logic [RATE_W-1:0] div_q;
  logic [AW-1:0]     idx_a, idx_b;
  logic [AW-1:0]     j;
  logic [IW-1:0]     mean_full;
  logic [31:0]       mean_ext;
  logic [MEAN_W-1:0] mean_sat;

  // Descending rank (fraction * WINDOW) >> 16 as an ascending index.
  assign idx_a = ~frac_a[FRAC_W-1 -: AW];
  assign idx_b = ~frac_b[FRAC_W-1 -: AW];

  assign j = k[AW-1:0] - 1'b1;

  // Mean interval, saturated to the field width.
  assign mean_full = sum[SUMW-1:AW];
  assign mean_ext  = 32'(mean_full);
  assign mean_sat  = (mean_ext > 32'(MEAN_MAX)) ? MEAN_MAX : mean_ext[MEAN_W-1:0];

  assign status.clear_done = (state != ST_CLEAR);

  always_comb begin
    case (div_sel)
      2'd0:    div_dvs = newest;
      2'd1:    div_dvs = cap_a;
      default: div_dvs = cap_b;
    endcase
  end

  fiws_div #(.IW(IW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr == AW'(WINDOW - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (item_avail) begin
          state_next = item_data[IW] ? ST_RING_RD : ST_SWEEP;
        end
      end
      ST_RING_RD:   state_next = ST_RING_UPD;
      ST_RING_UPD:  state_next = ST_SWEEP;
      ST_SWEEP:     if (k == CW'(WINDOW)) state_next = ST_SWEEP_END;
      ST_SWEEP_END: state_next = ST_DIVIDE;
      ST_DIVIDE:    if (div_done && div_sel == 2'd2) state_next = ST_OUTPUT;
      ST_OUTPUT:    if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory controls and one step of the remove-and-insert sweep.
  always_comb begin
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    ring_addr  = ptr;
    ring_wdata = cur_iv;
    sort_re    = 1'b0;
    sort_raddr = k[AW-1:0];
    sort_we    = 1'b0;
    sort_waddr = j;
    sort_wdata = sort_q;
    keep_cap   = 1'b0;
    ph_next    = phase;
    carry_next = carry;
    item_pop   = (state == ST_IDLE) && item_avail;
    out_load   = (state == ST_OUTPUT) && (!out_valid || !out_stall);
    div_start  = (state == ST_DIVIDE) && div_go;
    case (state)
      ST_CLEAR: begin
        ring_we    = 1'b1;
        ring_addr  = clr;
        ring_wdata = '0;
        sort_we    = 1'b1;
        sort_waddr = clr;
        sort_wdata = '0;
      end
      ST_RING_RD: begin
        ring_re = 1'b1;
      end
      ST_RING_UPD: begin
        ring_we = 1'b1;
      end
      ST_SWEEP: begin
        sort_re = (k != CW'(WINDOW));
        if (k != '0) begin
          if (!cur_taken) begin
            // First item: the sorted window is only read back.
            sort_we = 1'b1;
          end else if (left) begin
            // New value not below the dropped one: shift entries down.
            case (phase)
              PH_SEEK: begin
                if (sort_q == old_v) begin
                  ph_next = PH_SHIFT;
                end else begin
                  sort_we = 1'b1;
                end
              end
              PH_SHIFT: begin
                sort_we    = 1'b1;
                sort_waddr = j - 1'b1;
                if (sort_q > cur_iv) begin
                  // The entry read here stays in place; capture it as is.
                  sort_wdata = cur_iv;
                  keep_cap   = 1'b1;
                  ph_next    = PH_COPY;
                end
              end
              default: sort_we = 1'b1;
            endcase
          end else begin
            // New value below the dropped one: shift entries up.
            case (phase)
              PH_SEEK: begin
                sort_we = 1'b1;
                if (sort_q == old_v) begin
                  sort_wdata = cur_iv;
                  ph_next    = PH_COPY;
                end else if (sort_q > cur_iv) begin
                  sort_wdata = cur_iv;
                  carry_next = sort_q;
                  ph_next    = PH_SHIFT;
                end
              end
              PH_SHIFT: begin
                sort_we    = 1'b1;
                sort_wdata = carry;
                carry_next = sort_q;
                if (sort_q == old_v) begin
                  ph_next = PH_COPY;
                end
              end
              default: sort_we = 1'b1;
            endcase
          end
        end
      end
      ST_SWEEP_END: begin
        // The new value goes last when nothing above it remained.
        if (cur_taken && left && phase == PH_SHIFT) begin
          sort_we    = 1'b1;
          sort_waddr = AW'(WINDOW - 1);
          sort_wdata = cur_iv;
        end
      end
      default: ;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_addr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_q <= ring[ring_addr];
    end
    if (sort_we) begin
      sorted[sort_waddr] <= sort_wdata;
    end
    if (sort_re) begin
      sort_q <= sorted[sort_raddr];
    end
  end

  // Datapath and sequencer registers.
  always_ff @(posedge clk) begin
    if (sort_we && sort_waddr == idx_a) begin
      cap_a <= sort_wdata;
    end else if (keep_cap && j == idx_a) begin
      cap_a <= sort_q;
    end
    if (sort_we && sort_waddr == idx_b) begin
      cap_b <= sort_wdata;
    end else if (keep_cap && j == idx_b) begin
      cap_b <= sort_q;
    end
    if (out_load) begin
      current_rate_q8  <= rate_cur;
      mean_interval_us <= mean_sat;
      low_rate_a_q8    <= rate_a;
      low_rate_b_q8    <= rate_b;
      sample_taken     <= cur_taken;
    end
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= PH_SEEK;
      clr       <= '0;
      ptr       <= '0;
      sum       <= '0;
      newest    <= '0;
      div_go    <= 1'b0;
      div_sel   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          if (item_pop) begin
            cur_iv    <= item_data[IW-1:0];
            cur_taken <= item_data[IW];
            k         <= '0;
            phase     <= PH_SEEK;
          end
        end
        ST_RING_UPD: begin
          old_v  <= ring_q;
          left   <= (cur_iv >= ring_q);
          sum    <= sum - SUMW'(ring_q) + SUMW'(cur_iv);
          ptr    <= ptr + 1'b1;
          newest <= cur_iv;
        end
        ST_SWEEP: begin
          k     <= k + 1'b1;
          phase <= ph_next;
          carry <= carry_next;
        end
        ST_SWEEP_END: begin
          div_sel <= 2'd0;
          div_go  <= 1'b1;
        end
        ST_DIVIDE: begin
          if (div_start) begin
            div_go <= 1'b0;
          end
          if (div_done) begin
            case (div_sel)
              2'd0:    rate_cur <= div_q;
              2'd1:    rate_a   <= div_q;
              default: rate_b   <= div_q;
            endcase
            if (div_sel != 2'd2) begin
              div_sel <= div_sel + 2'd1;
              div_go  <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
